[rtl/bmhq_pkg.sv]
// bmhq_pkg: shared types, widths and codes of the binary min-heap queue.
// No dependencies; the interfaces, bmhq_seq and the top level refer to it by scoped names.
package bmhq_pkg;

   localparam int unsigned HEAP_DEPTH_DEF = 4096;
   localparam int unsigned COST_W         = 32;
   localparam int unsigned NODE_W         = 10;
   localparam int unsigned STATUS_W       = 2;
   localparam int unsigned FILL_W         = 13;
   localparam int unsigned ENTRY_W        = COST_W + NODE_W;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COST_W-1:0] cost;
      logic [NODE_W-1:0]        node;
   } entry_type;

   typedef struct packed {
      op_type    op;
      entry_type entry;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [COST_W-1:0] cost;
      logic [NODE_W-1:0]        node;
      logic [FILL_W-1:0]        fill;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CHECK,
      ST_UP_CMP,
      ST_POP_ROOT,
      ST_POP_LAST,
      ST_DN_CHECK,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_MOVE,
      ST_FINISH
   } state_type;

endpackage

[rtl/bmhq_if.sv]
// bmhq_req_if / bmhq_rsp_if: valid/ready channels of the heap queue.
// Depends on bmhq_pkg for field widths.
interface bmhq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               operation;
   logic signed [bmhq_pkg::COST_W-1:0] cost;
   logic [bmhq_pkg::NODE_W-1:0]        node;

   modport source(output valid, operation, cost, node, input ready);
   modport sink(input valid, operation, cost, node, output ready);
endinterface

interface bmhq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bmhq_pkg::STATUS_W-1:0]      status;
   logic signed [bmhq_pkg::COST_W-1:0] out_cost;
   logic [bmhq_pkg::NODE_W-1:0]        out_node;
   logic [bmhq_pkg::FILL_W-1:0]        fill;

   modport source(output valid, status, out_cost, out_node, fill, input ready);
   modport sink(input valid, status, out_cost, out_node, fill, output ready);
endinterface

[rtl/bmhq_ram.sv]
// bmhq_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module bmhq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/bmhq_seq.sv]
// bmhq_seq: heap sequencer with one shared cost comparator; walks sift-up
// and sift-down one level at a time through the heap RAM. Uses bmhq_pkg.
module bmhq_seq #(
   parameter int unsigned HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF,
   localparam int unsigned AW = $clog2(HEAP_DEPTH),
   localparam int unsigned CW = $clog2(HEAP_DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  bmhq_pkg::req_type                req,
   output logic                             idle,
   input  logic                             out_free,
   output logic                             done,
   output bmhq_pkg::result_type             result,
   output logic                             ram_wr_en,
   output logic [AW-1:0]                    ram_wr_addr,
   output logic [bmhq_pkg::ENTRY_W-1:0]     ram_wr_data,
   output logic                             ram_rd_en,
   output logic [AW-1:0]                    ram_rd_addr,
   input  logic [bmhq_pkg::ENTRY_W-1:0]     ram_rd_data
);

   localparam int unsigned IW = CW + 1;

   bmhq_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        now_ff, now_in;
   bmhq_pkg::entry_type  item_ff, item_in;
   bmhq_pkg::entry_type  best_ff, best_in;
   logic [AW-1:0]        best_idx_ff, best_idx_in;
   logic                 best_child_ff, best_child_in;
   bmhq_pkg::result_type res_ff, res_in;

   bmhq_pkg::entry_type  rd_entry;
   logic [IW-1:0]        left_ix, right_ix, count_wide;
   logic                 has_left, has_right, is_full;
   logic [AW-1:0]        parent_ix;

   // shared comparator
   logic signed [bmhq_pkg::COST_W-1:0] cmp_a, cmp_b;
   logic                               cmp_less;

   assign rd_entry   = bmhq_pkg::entry_type'(ram_rd_data);
   assign count_wide = IW'(count_ff);
   assign left_ix    = (IW'(now_ff) << 1) | IW'(1);
   assign right_ix   = left_ix + IW'(1);
   assign has_left   = left_ix < count_wide;
   assign has_right  = right_ix < count_wide;
   assign parent_ix  = (now_ff - AW'(1)) >> 1;
   assign is_full    = count_ff == CW'(HEAP_DEPTH);
   assign idle       = state_ff == bmhq_pkg::ST_IDLE;
   assign result     = res_ff;

   always_comb begin
      cmp_a = rd_entry.cost;
      cmp_b = item_ff.cost;
      case (state_ff)
         bmhq_pkg::ST_UP_CMP: begin
            cmp_a = item_ff.cost;
            cmp_b = rd_entry.cost;
         end
         bmhq_pkg::ST_DN_RIGHT: begin
            cmp_b = best_ff.cost;
         end
         default: begin
         end
      endcase
   end
   assign cmp_less = cmp_a < cmp_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            if (start) begin
               if (req.op == bmhq_pkg::OP_PUSH) begin
                  state_in = is_full ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_UP_CHECK;
               end else begin
                  state_in = (count_ff == '0) ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_POP_ROOT;
               end
            end
         end
         bmhq_pkg::ST_UP_CHECK: begin
            state_in = (now_ff == '0) ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_UP_CMP;
         end
         bmhq_pkg::ST_UP_CMP: begin
            state_in = cmp_less ? bmhq_pkg::ST_UP_CHECK : bmhq_pkg::ST_FINISH;
         end
         bmhq_pkg::ST_POP_ROOT: begin
            state_in = (count_ff == CW'(1)) ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_POP_LAST;
         end
         bmhq_pkg::ST_POP_LAST: begin
            state_in = bmhq_pkg::ST_DN_CHECK;
         end
         bmhq_pkg::ST_DN_CHECK: begin
            state_in = has_left ? bmhq_pkg::ST_DN_LEFT : bmhq_pkg::ST_FINISH;
         end
         bmhq_pkg::ST_DN_LEFT: begin
            state_in = has_right ? bmhq_pkg::ST_DN_RIGHT : bmhq_pkg::ST_DN_MOVE;
         end
         bmhq_pkg::ST_DN_RIGHT: begin
            state_in = bmhq_pkg::ST_DN_MOVE;
         end
         bmhq_pkg::ST_DN_MOVE: begin
            state_in = best_child_ff ? bmhq_pkg::ST_DN_CHECK : bmhq_pkg::ST_FINISH;
         end
         bmhq_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = bmhq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmhq_pkg::ST_IDLE;
         end
      endcase
   end

   // RAM port and handshake outputs
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = now_ff;
      ram_wr_data = item_ff;
      done        = 1'b0;
      unique case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            // fetch the root early; harmless if the heap turns out empty
            ram_rd_en = start && (req.op == bmhq_pkg::OP_POP);
         end
         bmhq_pkg::ST_UP_CHECK: begin
            ram_rd_en   = now_ff != '0;
            ram_rd_addr = parent_ix;
            ram_wr_en   = now_ff == '0;
         end
         bmhq_pkg::ST_UP_CMP: begin
            ram_wr_en = 1'b1;
            if (cmp_less) begin
               ram_wr_data = rd_entry;
            end
         end
         bmhq_pkg::ST_POP_ROOT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(count_ff - CW'(1));
         end
         bmhq_pkg::ST_POP_LAST: begin
         end
         bmhq_pkg::ST_DN_CHECK: begin
            ram_rd_en   = has_left;
            ram_rd_addr = left_ix[AW-1:0];
            ram_wr_en   = !has_left;
         end
         bmhq_pkg::ST_DN_LEFT: begin
            ram_rd_en   = has_right;
            ram_rd_addr = right_ix[AW-1:0];
         end
         bmhq_pkg::ST_DN_RIGHT: begin
         end
         bmhq_pkg::ST_DN_MOVE: begin
            ram_wr_en = 1'b1;
            if (best_child_ff) begin
               ram_wr_data = best_ff;
            end
         end
         bmhq_pkg::ST_FINISH: begin
            done = out_free;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      count_in      = count_ff;
      now_in        = now_ff;
      item_in       = item_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_child_in = best_child_ff;
      res_in        = res_ff;
      case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            if (start) begin
               res_in.status = bmhq_pkg::STATUS_DONE;
               res_in.cost   = '0;
               res_in.node   = '0;
               res_in.fill   = bmhq_pkg::FILL_W'(count_ff);
               item_in       = req.entry;
               now_in        = AW'(count_ff);
               if (req.op == bmhq_pkg::OP_PUSH) begin
                  if (is_full) begin
                     res_in.status = bmhq_pkg::STATUS_FULL;
                  end else begin
                     count_in    = count_ff + CW'(1);
                     res_in.fill = bmhq_pkg::FILL_W'(count_ff + CW'(1));
                  end
               end else if (count_ff == '0) begin
                  res_in.status = bmhq_pkg::STATUS_EMPTY;
               end
            end
         end
         bmhq_pkg::ST_UP_CMP: begin
            if (cmp_less) begin
               now_in = parent_ix;
            end
         end
         bmhq_pkg::ST_POP_ROOT: begin
            res_in.cost = rd_entry.cost;
            res_in.node = rd_entry.node;
            res_in.fill = bmhq_pkg::FILL_W'(count_ff - CW'(1));
            count_in    = count_ff - CW'(1);
         end
         bmhq_pkg::ST_POP_LAST: begin
            item_in = rd_entry;
            now_in  = '0;
         end
         bmhq_pkg::ST_DN_LEFT: begin
            // left wins only when strictly cheaper than the moving entry
            best_idx_in   = left_ix[AW-1:0];
            best_child_in = cmp_less;
            best_in       = cmp_less ? rd_entry : item_ff;
         end
         bmhq_pkg::ST_DN_RIGHT: begin
            if (cmp_less) begin
               best_in       = rd_entry;
               best_idx_in   = right_ix[AW-1:0];
               best_child_in = 1'b1;
            end
         end
         bmhq_pkg::ST_DN_MOVE: begin
            if (best_child_ff) begin
               now_in = best_idx_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhq_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      item_ff       <= item_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_child_ff <= best_child_in;
      res_ff        <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH))
      else $error("entry count above heap depth");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (IW'(ram_wr_addr) < count_wide))
      else $error("heap write outside held entries");

   a_left_after_check: assert property (@(posedge clock) disable iff (reset)
      state_ff == bmhq_pkg::ST_DN_LEFT |-> $past(state_ff) == bmhq_pkg::ST_DN_CHECK)
      else $error("left child compare without a child read");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == bmhq_pkg::ST_IDLE)
      else $error("sequencer did not return to idle after a result");

endmodule

[rtl/binary_min_heap_queue.sv]
// binary_min_heap_queue: top level of the min-heap priority queue.
// Depends on bmhq_pkg, bmhq_if, bmhq_ram and bmhq_seq.
//
//  channel   dir   handshake          beat contents
//  req_chan  in    valid/ready        operation, cost, node
//  rsp_chan  out   valid/ready        status, out_cost, out_node, fill
//
// A push puts the new entry at the end and moves it up, copying each dearer
// parent down, until it reaches the root or a parent that is not dearer. A
// pop reads the root and the last entry, then sinks the last entry one level
// at a time, moving up the cheapest child when it is strictly cheaper;
// on a tie the left child wins. The heap RAM's single read port and its
// registered read set the pace. Full and empty cases go straight to the result.
// Synchronous reset empties the heap at once; no RAM clearing pass is needed.
// req_chan.ready is high only while the sequencer is idle; a result waits in
// the output register and a finished beat holds until that register is free.
module binary_min_heap_queue #(
   parameter int unsigned HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   bmhq_req_if.sink    req_chan,
   bmhq_rsp_if.source  rsp_chan
);

   localparam int unsigned AW = $clog2(HEAP_DEPTH);

   logic                            start, idle, done, out_free;
   bmhq_pkg::req_type               req;
   bmhq_pkg::result_type            result;
   logic                            ram_wr_en, ram_rd_en;
   logic [AW-1:0]                   ram_wr_addr, ram_rd_addr;
   logic [bmhq_pkg::ENTRY_W-1:0]    ram_wr_data, ram_rd_data;

   logic                            rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::result_type            rsp_data_ff, rsp_data_in;

   assign req_chan.ready = idle;
   assign start          = req_chan.valid && idle;
   assign req.op         = bmhq_pkg::op_type'(req_chan.operation);
   assign req.entry.cost = req_chan.cost;
   assign req.entry.node = req_chan.node;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_data_ff.status;
   assign rsp_chan.out_cost = rsp_data_ff.cost;
   assign rsp_chan.out_node = rsp_data_ff.node;
   assign rsp_chan.fill     = rsp_data_ff.fill;

   bmhq_seq #(
      .HEAP_DEPTH(HEAP_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req),
      .idle        (idle),
      .out_free    (out_free),
      .done        (done),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   bmhq_ram #(
      .WIDTH(bmhq_pkg::ENTRY_W),
      .DEPTH(HEAP_DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
